/* src/nsc_pkg.sv */
package nsc_pkg;

  localparam int unsigned NTP_W    = 32;
  localparam int unsigned YEAR_W   = 12;
  localparam int unsigned MONTH_W  = 4;
  localparam int unsigned DAY_W    = 5;
  localparam int unsigned HOUR_W   = 5;
  localparam int unsigned MINUTE_W = 6;
  localparam int unsigned SECOND_W = 6;

  localparam int unsigned DAYS_W   = 16;  // whole days since 2020, below 49711
  localparam int unsigned SOD_W    = 17;  // seconds of day
  localparam int unsigned CYC_W    = 6;   // four-year cycles since 2020
  localparam int unsigned DIC_W    = 11;  // day within a four-year cycle
  localparam int unsigned SOH_W    = 12;  // seconds of hour
  localparam int unsigned DOY_W    = 9;   // day of year from 0

  localparam logic [NTP_W-1:0]  SECS_TO_2020   = 32'd3786825600;
  localparam int unsigned       SECS_PER_DAY   = 86400;
  localparam int unsigned       SECS_PER_HOUR  = 3600;
  localparam int unsigned       SECS_PER_MIN   = 60;
  localparam int unsigned       DAYS_PER_CYCLE = 1461;
  localparam logic [YEAR_W-1:0] BASE_YEAR      = 12'd2020;

  // First day of year in each cycle year (the first year is leap)
  localparam logic [DIC_W-1:0] YEAR2_START = 11'd366;
  localparam logic [DIC_W-1:0] YEAR3_START = 11'd731;
  localparam logic [DIC_W-1:0] YEAR4_START = 11'd1096;

  localparam int unsigned NUM_MONTHS = 12;

  // First day of each month in a common year, day of year from 0
  localparam logic [DOY_W-1:0] MONTH_START [NUM_MONTHS] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };

  typedef struct packed {
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
  } md_t;

  function automatic md_t month_of(input logic [DOY_W-1:0] doy, input logic leap);
    md_t                res;
    logic [DOY_W-1:0]   start;
    logic [DOY_W-1:0]   base;
    logic [MONTH_W-1:0] idx;
    base = '0;
    idx  = '0;
    for (int m = 1; m < NUM_MONTHS; m++) begin
      start = MONTH_START[MONTH_W'(m)] + DOY_W'((leap && m >= 2) ? 1 : 0);
      if (doy >= start) begin
        base = start;
        idx  = MONTH_W'(m);
      end
    end
    res.month = idx + MONTH_W'(1);
    res.day   = DAY_W'(doy - base) + DAY_W'(1);
    return res;
  endfunction

endpackage

/* src/nsc_if.sv */
interface nsc_req_if;
  import nsc_pkg::*;

  logic              valid;
  logic              ready;
  logic [NTP_W-1:0]  ntp_seconds;

  modport source (output valid, output ntp_seconds, input ready);
  modport sink   (input valid, input ntp_seconds, output ready);
endinterface

interface nsc_res_if;
  import nsc_pkg::*;

  logic                valid;
  logic                ready;
  logic [YEAR_W-1:0]   year;
  logic [MONTH_W-1:0]  month;
  logic [DAY_W-1:0]    day;
  logic [HOUR_W-1:0]   hour;
  logic [MINUTE_W-1:0] minute;
  logic [SECOND_W-1:0] second;

  modport source (output valid, output year, output month, output day,
                  output hour, output minute, output second, input ready);
  modport sink   (input valid, input year, input month, input day,
                  input hour, input minute, input second, output ready);
endinterface

/* src/ntp_seconds_to_calendar.sv */
// Channel  Dir  Payload                                   Moves
// req_i    in   ntp_seconds[31:0]                         valid & ready
// res_o    out  year, month, day, hour, minute, second    valid & ready
//
// Ten register stages; one request enters per cycle while the output is not stalled.
// The depth is set by three chained constant dividers (day, hour/cycle, minute)
// of three stages each, behind the epoch subtraction stage.
// The whole pipeline advances together; a stalled result freezes every stage.
// Reset clears the valid bits only.
module ntp_seconds_to_calendar (
  input  logic       clk_i,
  input  logic       rst_ni,
  nsc_req_if.sink    req_i,
  nsc_res_if.source  res_o
);
  import nsc_pkg::*;

  localparam int unsigned LAT = 10;

  logic              en;
  logic [LAT-1:0]    vld_d, vld_q;

  logic [NTP_W-1:0]  t_d, t_q;
  logic [DAYS_W-1:0] days;
  logic [SOD_W-1:0]  sod;
  logic [CYC_W-1:0]  cyc;
  logic [DIC_W-1:0]  dic;
  logic [HOUR_W-1:0] hour;
  logic [SOH_W-1:0]  soh;
  logic [MINUTE_W-1:0] minute;
  logic [SECOND_W-1:0] second;

  logic [1:0]         yic;
  logic [DIC_W-1:0]   ystart;
  logic [YEAR_W-1:0]  year7_d, year7_q, year8_q, year9_q;
  logic [DOY_W-1:0]   doy7_d, doy7_q;
  logic               leap7_q;
  logic [HOUR_W-1:0]  hour7_q, hour8_q, hour9_q;
  md_t                md8_d, md8_q, md9_q;

  assign en    = !vld_q[LAT-1] || res_o.ready;
  assign vld_d = {vld_q[LAT-2:0], req_i.valid};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= vld_d;
    end
  end

  assign t_d = req_i.ntp_seconds - SECS_TO_2020;

  always_ff @(posedge clk_i) begin
    if (en) begin
      t_q <= t_d;
    end
  end

  nsc_cdiv #(
    .NUM_W(NTP_W), .QUO_W(DAYS_W), .REM_W(SOD_W), .DIVISOR(SECS_PER_DAY), .SHIFT(48)
  ) u_div_day (
    .clk_i, .en_i(en), .num_i(t_q), .quo_o(days), .rem_o(sod)
  );

  nsc_cdiv #(
    .NUM_W(DAYS_W), .QUO_W(CYC_W), .REM_W(DIC_W), .DIVISOR(DAYS_PER_CYCLE), .SHIFT(24)
  ) u_div_cyc (
    .clk_i, .en_i(en), .num_i(days), .quo_o(cyc), .rem_o(dic)
  );

  nsc_cdiv #(
    .NUM_W(SOD_W), .QUO_W(HOUR_W), .REM_W(SOH_W), .DIVISOR(SECS_PER_HOUR), .SHIFT(24)
  ) u_div_hour (
    .clk_i, .en_i(en), .num_i(sod), .quo_o(hour), .rem_o(soh)
  );

  nsc_cdiv #(
    .NUM_W(SOH_W), .QUO_W(MINUTE_W), .REM_W(SECOND_W), .DIVISOR(SECS_PER_MIN), .SHIFT(16)
  ) u_div_min (
    .clk_i, .en_i(en), .num_i(soh), .quo_o(minute), .rem_o(second)
  );

  // year within the four-year cycle; first year of each cycle is leap
  always_comb begin
    if (dic >= YEAR4_START) begin
      yic    = 2'd3;
      ystart = YEAR4_START;
    end else if (dic >= YEAR3_START) begin
      yic    = 2'd2;
      ystart = YEAR3_START;
    end else if (dic >= YEAR2_START) begin
      yic    = 2'd1;
      ystart = YEAR2_START;
    end else begin
      yic    = 2'd0;
      ystart = '0;
    end
  end

  assign year7_d = BASE_YEAR + YEAR_W'({cyc, yic});
  assign doy7_d  = DOY_W'(dic - ystart);
  assign md8_d   = month_of(doy7_q, leap7_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      year7_q <= year7_d;
      doy7_q  <= doy7_d;
      leap7_q <= (yic == 2'd0);
      hour7_q <= hour;
      year8_q <= year7_q;
      md8_q   <= md8_d;
      hour8_q <= hour7_q;
      year9_q <= year8_q;
      md9_q   <= md8_q;
      hour9_q <= hour8_q;
    end
  end

  assign req_i.ready  = en;
  assign res_o.valid  = vld_q[LAT-1];
  assign res_o.year   = year9_q;
  assign res_o.month  = md9_q.month;
  assign res_o.day    = md9_q.day;
  assign res_o.hour   = hour9_q;
  assign res_o.minute = minute;
  assign res_o.second = second;

endmodule

/* src/nsc_cdiv.sv */
// Three-stage divide by a constant: reciprocal multiply, remainder, correction.
module nsc_cdiv #(
  parameter int unsigned NUM_W   = 32,
  parameter int unsigned QUO_W   = 16,
  parameter int unsigned REM_W   = 17,
  parameter int unsigned DIVISOR = 86400,
  parameter int unsigned SHIFT   = 48
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [NUM_W-1:0] num_i,
  output logic [QUO_W-1:0] quo_o,
  output logic [REM_W-1:0] rem_o
);

  localparam logic [63:0] MUL   = (64'd1 << SHIFT) / DIVISOR;
  localparam int unsigned MUL_W = $clog2(MUL + 64'd1);
  localparam int unsigned PRD_W = NUM_W + MUL_W;
  localparam logic [NUM_W-1:0] DIV_N = NUM_W'(DIVISOR);

  logic [PRD_W-1:0] prod_d, prod_q;
  logic [NUM_W-1:0] num_q;
  logic [QUO_W-1:0] q0_d, q0_q;
  logic [NUM_W-1:0] r0_d, r0_q;
  logic [QUO_W-1:0] quo_d, quo_q;
  logic [REM_W-1:0] rem_d, rem_q;

  assign prod_d = {{MUL_W{1'b0}}, num_i} * {{NUM_W{1'b0}}, MUL[MUL_W-1:0]};

  // floor reciprocal: estimate is exact or one short
  assign q0_d = prod_q[SHIFT +: QUO_W];
  assign r0_d = num_q - NUM_W'({{NUM_W{1'b0}}, q0_d} * DIV_N);

  always_comb begin
    if (r0_q >= DIV_N) begin
      quo_d = q0_q + QUO_W'(1);
      rem_d = REM_W'(r0_q - DIV_N);
    end else begin
      quo_d = q0_q;
      rem_d = REM_W'(r0_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      num_q  <= num_i;
      q0_q   <= q0_d;
      r0_q   <= r0_d;
      quo_q  <= quo_d;
      rem_q  <= rem_d;
    end
  end

  assign quo_o = quo_q;
  assign rem_o = rem_q;

endmodule

/* src/nsc_checker.sv */
module nsc_props (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         req_ready_i,
  input logic                         res_valid_i,
  input logic                         res_ready_i,
  input logic [nsc_pkg::YEAR_W-1:0]   year_i,
  input logic [nsc_pkg::MONTH_W-1:0]  month_i,
  input logic [nsc_pkg::DAY_W-1:0]    day_i,
  input logic [nsc_pkg::HOUR_W-1:0]   hour_i,
  input logic [nsc_pkg::MINUTE_W-1:0] minute_i,
  input logic [nsc_pkg::SECOND_W-1:0] second_i
);
  import nsc_pkg::*;

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(year_i) && $stable(month_i)
      && $stable(day_i) && $stable(hour_i) && $stable(minute_i) && $stable(second_i))
    else $error("stalled result changed");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !res_valid_i |-> req_ready_i)
    else $error("request refused with empty output");

  a_year_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> year_i >= BASE_YEAR && year_i <= 12'd2156)
    else $error("year out of range");

  a_date_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> month_i >= 4'd1 && month_i <= 4'd12 && day_i >= 5'd1
      && (month_i != 4'd2 || day_i <= 5'd29)
      && ((month_i != 4'd4 && month_i != 4'd6 && month_i != 4'd9 && month_i != 4'd11)
          || day_i <= 5'd30))
    else $error("date out of range");

  a_time_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> hour_i <= 5'd23 && minute_i <= 6'd59 && second_i <= 6'd59)
    else $error("time of day out of range");

endmodule

bind ntp_seconds_to_calendar nsc_props u_nsc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_ready_i (req_i.ready),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .year_i      (res_o.year),
  .month_i     (res_o.month),
  .day_i       (res_o.day),
  .hour_i      (res_o.hour),
  .minute_i    (res_o.minute),
  .second_i    (res_o.second)
);
